// File: src/som_pkg.sv
// ----------------------------------------------------------------------------
// SOM package
// Request and response payload types and schedule constants for the map trainer.
// ----------------------------------------------------------------------------
package som_pkg;

   localparam logic [1:0] CMD_PATTERN = 2'd0;
   localparam logic [1:0] CMD_EPOCH   = 2'd1;
   localparam logic [1:0] CMD_WRITE   = 2'd2;
   localparam logic [1:0] CMD_READ    = 2'd3;

   localparam logic [1:0] KIND_WINNER = 2'd0;
   localparam logic [1:0] KIND_EPOCH  = 2'd1;
   localparam logic [1:0] KIND_WEIGHT = 2'd2;

   localparam logic [2:0] CSR_NEURON_COUNT = 3'd0;
   localparam logic [2:0] CSR_INPUT_DIM    = 3'd1;
   localparam logic [2:0] CSR_START_RADIUS = 3'd2;
   localparam logic [2:0] CSR_GLOBAL       = 3'd3;
   localparam logic [2:0] CSR_TRANSITION   = 3'd4;
   localparam logic [2:0] CSR_RADIUS_STEP  = 3'd5;
   localparam logic [2:0] CSR_ETA_STEP     = 3'd6;

   localparam logic [15:0] ETA_HIGH  = 16'd58982;
   localparam logic [15:0] ETA_LOW   = 16'd6554;
   localparam logic [16:0] FINE_MAX  = 17'h1FFFF;
   localparam logic [16:0] EPOCH_MAX = 17'h1FFFF;
   localparam logic [36:0] DIST_MAX  = {37{1'b1}};

   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] value;
      logic [5:0]         neuron;
      logic [3:0]         component;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [5:0]         winner;
      logic [36:0]        min_distance_sq;
      logic signed [15:0] weight_value;
      logic [7:0]         radius_now;
      logic [15:0]        eta_now;
   } rsp_type;

endpackage

// File: src/som_1d_winner_and_update.sv
// ----------------------------------------------------------------------------
// SOM 1D winner search and update
// One-dimensional Kohonen map trainer built around a single weight memory.
// ----------------------------------------------------------------------------
// Weight writes and pattern components that do not end a pattern are taken without busy.
// Epoch and weight read requests pass through one busy state that registers the response.
// Training runs S_DADDR and S_DMAC per component of each of N neurons, then S_DSUM;
// S_RANGE sends the winner response, then M neurons (at most 2*R+1) are updated through
// S_UADDR, S_UMUL and S_UWRITE per component. The receiver cannot stall.
// Reset is synchronous and restores configuration, state and schedule; memory is not cleared.
module som_1d_winner_and_update
   import som_pkg::*;
#(
   parameter int MAX_NEURONS = 64,
   parameter int MAX_DIM     = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   localparam int NB   = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
   localparam int DB   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int AB   = NB + DB;
   localparam int NCB  = $clog2(MAX_NEURONS + 1);
   localparam int DCB  = $clog2(MAX_DIM + 1);
   localparam int LB   = NB + 10;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_READ   = 4'd1;
   localparam logic [3:0] S_RDOUT  = 4'd2;
   localparam logic [3:0] S_DADDR  = 4'd3;
   localparam logic [3:0] S_DMAC   = 4'd4;
   localparam logic [3:0] S_RANGE  = 4'd5;
   localparam logic [3:0] S_UADDR  = 4'd6;
   localparam logic [3:0] S_UMUL   = 4'd7;
   localparam logic [3:0] S_UWRITE = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;
   localparam logic [3:0] S_DSUM   = 4'd10;

   // Configuration registers.
   logic [6:0]         ncount_ff;
   logic [4:0]         idim_ff;
   logic [5:0]         sradius_ff;
   logic [15:0]        gepochs_ff, tepochs_ff, estep_ff;
   logic signed [15:0] rstep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ncount_ff  <= 7'd64;
         idim_ff    <= 5'd16;
         sradius_ff <= 6'd4;
         gepochs_ff <= '0;
         tepochs_ff <= 16'd1;
         rstep_ff   <= '0;
         estep_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_NEURON_COUNT: ncount_ff  <= csr_data[6:0];
            CSR_INPUT_DIM:    idim_ff    <= csr_data[4:0];
            CSR_START_RADIUS: sradius_ff <= csr_data[5:0];
            CSR_GLOBAL:       gepochs_ff <= csr_data;
            CSR_TRANSITION:   tepochs_ff <= csr_data;
            CSR_RADIUS_STEP:  rstep_ff   <= csr_data;
            CSR_ETA_STEP:     estep_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   logic [NCB-1:0] n_use;
   logic [DCB-1:0] d_use;
   always_comb begin
      if (ncount_ff == '0) begin
         n_use = NCB'(1);
      end else if (32'(ncount_ff) > MAX_NEURONS) begin
         n_use = NCB'(MAX_NEURONS);
      end else begin
         n_use = NCB'(ncount_ff);
      end
      if (idim_ff == '0) begin
         d_use = DCB'(1);
      end else if (32'(idim_ff) > MAX_DIM) begin
         d_use = DCB'(MAX_DIM);
      end else begin
         d_use = DCB'(idim_ff);
      end
   end

   // Schedule.
   logic       epoch_go;
   logic [7:0] radius_cur;
   logic [15:0] eta_cur;

   som_sched u_sched (
      .clock             (clock),
      .reset             (reset),
      .advance           (epoch_go),
      .start_radius      (sradius_ff),
      .global_epochs     (gepochs_ff),
      .transition_epochs (tepochs_ff),
      .radius_step       (rstep_ff),
      .eta_step          (estep_ff),
      .radius_current    (radius_cur),
      .eta_current       (eta_cur)
   );

   // Memories.
   logic [15:0] wmem [1 << AB];
   logic [15:0] pmem [MAX_DIM];
   logic          w_we;
   logic [AB-1:0] w_waddr, w_raddr;
   logic [15:0]   w_wdata, w_rdata_ff;
   logic          p_we;
   logic [DB-1:0] p_waddr, p_raddr;
   logic [15:0]   p_wdata, p_rdata_ff;

   always_ff @(posedge clock) begin
      if (w_we) begin
         wmem[w_waddr] <= w_wdata;
      end
      w_rdata_ff <= wmem[w_raddr];
      if (p_we) begin
         pmem[p_waddr] <= p_wdata;
      end
      p_rdata_ff <= pmem[p_raddr];
   end

   // Control.
   logic [3:0]     state_ff, state_in;
   logic [NB-1:0]  j_ff, j_in;
   logic [DB-1:0]  k_ff, k_in;
   logic           klast_ff, klast_in;
   logic           jlast_ff, jlast_in;
   logic [36:0]    sum_ff, sum_in;
   logic [36:0]    best_ff, best_in;
   logic [NB-1:0]  win_ff, win_in;
   logic [NB-1:0]  hi_ff, hi_in;
   logic           rok_ff, rok_in;
   logic [AB-1:0]  addr_ff, addr_in;
   logic signed [15:0] wold_ff, wold_in;
   logic signed [33:0] prod_ff, prod_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic signed [16:0] diff_c;
   logic [33:0]        sq_c;
   logic [37:0]        acc_c;
   logic signed [LB-1:0] lo_c, hi_c;
   logic signed [17:0] delta_c;
   logic signed [17:0] nw_c;
   logic               in_range;

   assign in_range = (32'(req_data.neuron) < MAX_NEURONS) &&
                     (32'(req_data.component) < MAX_DIM);

   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      klast_in     = klast_ff;
      jlast_in     = jlast_ff;
      sum_in       = sum_ff;
      best_in      = best_ff;
      win_in       = win_ff;
      hi_in        = hi_ff;
      rok_in       = rok_ff;
      addr_in      = addr_ff;
      wold_in      = wold_ff;
      prod_in      = prod_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      epoch_go     = 1'b0;
      w_we         = 1'b0;
      w_waddr      = addr_ff;
      w_wdata      = req_data.value;
      w_raddr      = {j_ff, k_ff};
      p_we         = 1'b0;
      p_waddr      = DB'(req_data.component);
      p_wdata      = req_data.value;
      p_raddr      = k_ff;
      diff_c       = $signed({p_rdata_ff[15], p_rdata_ff}) -
                     $signed({w_rdata_ff[15], w_rdata_ff});
      sq_c         = 34'(diff_c * diff_c);
      acc_c        = {1'b0, sum_ff} + {4'd0, sq_c};
      lo_c         = $signed(LB'(win_ff)) - $signed(LB'(radius_cur));
      hi_c         = $signed(LB'(win_ff)) + $signed(LB'(radius_cur));
      delta_c      = 18'(($signed(prod_ff) + 34'sd32768) >>> 16);
      nw_c         = 18'(wold_ff) + delta_c;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_data.command)
                  CMD_PATTERN: begin
                     if (32'(req_data.component) < MAX_DIM) begin
                        p_we = 1'b1;
                        if (32'(req_data.component) == 32'(d_use) - 1) begin
                           j_in     = '0;
                           k_in     = '0;
                           sum_in   = '0;
                           best_in  = '0;
                           win_in   = '0;
                           state_in = S_DADDR;
                        end
                     end
                  end
                  CMD_EPOCH: begin
                     epoch_go = 1'b1;
                     state_in = S_DONE;
                  end
                  CMD_WRITE: begin
                     w_we    = in_range;
                     w_waddr = {NB'(req_data.neuron), DB'(req_data.component)};
                  end
                  default: begin
                     rok_in   = in_range;
                     w_raddr  = {NB'(req_data.neuron), DB'(req_data.component)};
                     state_in = S_READ;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in.result_kind  = KIND_WEIGHT;
            rsp_in.weight_value = rok_ff ? w_rdata_ff : 16'd0;
            state_in = S_IDLE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in.result_kind = KIND_EPOCH;
            rsp_in.radius_now  = radius_cur;
            rsp_in.eta_now     = eta_cur;
            state_in = S_IDLE;
         end
         S_DADDR: begin
            // Memory address {j,k} is presented; data arrives next cycle.
            klast_in = (32'(k_ff) == 32'(d_use) - 1);
            jlast_in = (32'(j_ff) == 32'(n_use) - 1);
            if (32'(k_ff) == 32'(d_use) - 1) begin
               k_in = '0;
            end else begin
               k_in = k_ff + DB'(1);
            end
            state_in = S_DMAC;
         end
         S_DMAC: begin
            sum_in = acc_c > {1'b0, DIST_MAX} ? DIST_MAX : acc_c[36:0];
            if (klast_ff) begin
               state_in = S_DSUM;
            end else begin
               state_in = S_DADDR;
            end
         end
         S_DSUM: begin
            if (j_ff == '0 || sum_ff < best_ff) begin
               best_in = sum_ff;
               win_in  = j_ff;
            end
            sum_in = '0;
            if (jlast_ff) begin
               state_in = S_RANGE;
            end else begin
               j_in     = j_ff + NB'(1);
               state_in = S_DADDR;
            end
         end
         S_RANGE: begin
            rsp_valid_in = 1'b1;
            rsp_in.result_kind     = KIND_WINNER;
            rsp_in.winner          = 6'(win_ff);
            rsp_in.min_distance_sq = best_ff;
            j_in  = (lo_c < 0) ? '0 : lo_c[NB-1:0];
            hi_in = (hi_c > $signed(LB'(n_use) - LB'(1))) ?
                    NB'(n_use - NCB'(1)) : hi_c[NB-1:0];
            k_in  = '0;
            state_in = S_UADDR;
         end
         S_UADDR: begin
            addr_in  = {j_ff, k_ff};
            klast_in = (32'(k_ff) == 32'(d_use) - 1);
            jlast_in = (j_ff == hi_in);
            state_in = S_UMUL;
         end
         S_UMUL: begin
            wold_in  = w_rdata_ff;
            prod_in  = 34'(diff_c * $signed({1'b0, eta_cur}));
            state_in = S_UWRITE;
         end
         S_UWRITE: begin
            w_we = 1'b1;
            if (nw_c > 18'sd32767) begin
               w_wdata = 16'h7FFF;
            end else if (nw_c < -18'sd32768) begin
               w_wdata = 16'h8000;
            end else begin
               w_wdata = nw_c[15:0];
            end
            if (klast_ff) begin
               k_in = '0;
               if (jlast_ff) begin
                  state_in = S_IDLE;
               end else begin
                  j_in     = j_ff + NB'(1);
                  state_in = S_UADDR;
               end
            end else begin
               k_in     = k_ff + DB'(1);
               state_in = S_UADDR;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      j_ff     <= j_in;
      k_ff     <= k_in;
      klast_ff <= klast_in;
      jlast_ff <= jlast_in;
      sum_ff   <= sum_in;
      best_ff  <= best_in;
      win_ff   <= win_in;
      hi_ff    <= hi_in;
      rok_ff   <= rok_in;
      addr_ff  <= addr_in;
      wold_ff  <= wold_in;
      prod_ff  <= prod_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: src/som_sched.sv
// ----------------------------------------------------------------------------
// SOM epoch schedule
// Holds the epoch counter, radius and learning rate and advances them on request.
// ----------------------------------------------------------------------------
module som_sched
   import som_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [5:0]         start_radius,
   input  logic [15:0]        global_epochs,
   input  logic [15:0]        transition_epochs,
   input  logic signed [15:0] radius_step,
   input  logic [15:0]        eta_step,
   output logic [7:0]         radius_current,
   output logic [15:0]        eta_current
);

   logic [16:0] epoch_ff, epoch_in;
   logic [16:0] fine_ff, fine_in;
   logic [7:0]  radius_ff, radius_in;
   logic [15:0] eta_ff, eta_in;

   logic [16:0]        fine_base;
   logic [15:0]        eta_base;
   logic signed [18:0] fine_next;
   logic [17:0]        t_end;
   logic [9:0]         rounded;

   always_comb begin
      epoch_in  = epoch_ff;
      fine_in   = fine_ff;
      radius_in = radius_ff;
      eta_in    = eta_ff;
      fine_base = (epoch_ff == '0) ? {3'd0, start_radius, 8'd0} : fine_ff;
      eta_base  = (epoch_ff == '0) ? ETA_HIGH : eta_ff;
      t_end     = {2'd0, global_epochs} + {2'd0, transition_epochs};
      fine_next = $signed({2'b00, fine_base}) - 19'(radius_step);
      rounded   = '0;
      if (advance) begin
         fine_in = fine_base;
         eta_in  = eta_base;
         if (epoch_ff < {1'b0, global_epochs}) begin
            radius_in = {2'd0, start_radius};
            eta_in    = ETA_HIGH;
         end else if ({1'b0, epoch_ff} < t_end) begin
            if (fine_next < 0) begin
               fine_in = '0;
            end else if (fine_next > $signed({2'b00, FINE_MAX})) begin
               fine_in = FINE_MAX;
            end else begin
               fine_in = fine_next[16:0];
            end
            rounded   = 10'(({1'b0, fine_in} + 18'd128) >> 8);
            radius_in = (rounded > 10'd255) ? 8'd255 : rounded[7:0];
            eta_in    = (eta_base > eta_step) ? eta_base - eta_step : 16'd0;
         end else begin
            radius_in = '0;
            eta_in    = ETA_LOW;
         end
         if (epoch_ff != EPOCH_MAX) begin
            epoch_in = epoch_ff + 17'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff  <= '0;
         fine_ff   <= '0;
         radius_ff <= '0;
         eta_ff    <= '0;
      end else begin
         epoch_ff  <= epoch_in;
         fine_ff   <= fine_in;
         radius_ff <= radius_in;
         eta_ff    <= eta_in;
      end
   end

   assign radius_current = radius_ff;
   assign eta_current    = eta_ff;

endmodule
